/* hdl/psr_pkg.sv */
// Package for the polyline stitch resampler: widths, constants, state type.
// No dependencies; every other file depends on it.
package psr_pkg;
  localparam int CoordW   = 24;
  localparam int JumpW    = 23;
  localparam int EpsW     = 12;
  localparam int CfgW     = 23;
  localparam int MaxSteps = 62;
  localparam int DiffW    = CoordW + 1;
  localparam int SqW      = 2 * DiffW;
  localparam int LenW     = DiffW + 1;
  localparam int StepW    = 6;
  localparam int ProdW    = StepW + JumpW + DiffW;
  localparam int ThrW     = JumpW + StepW + 2;

  localparam logic [0:0] CfgJump = 1'b0;
  localparam logic [0:0] CfgEps  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_JX, ST_JY, ST_CNT, ST_FIRST,
    ST_DIVX, ST_DIVY, ST_EMIT, ST_LAST
  } psr_state_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              item_done;
    logic              path_done;
    logic              capped;
    logic              bad;
  } psr_res_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [DiffW+1:0] v);
    logic signed [DiffW+1:0] hi;
    logic signed [DiffW+1:0] lo;
    hi = (DiffW+2)'((64'sd1 <<< (CoordW-1)) - 1);
    lo = -hi - 1;
    if (v > hi) sat_coord = hi[CoordW-1:0];
    else if (v < lo) sat_coord = lo[CoordW-1:0];
    else sat_coord = v[CoordW-1:0];
  endfunction
endpackage

/* hdl/psr_if.sv */
// Valid/ready channel interfaces for the vertex input and the stitch output.
// Depends on psr_pkg for the coordinate width.
interface psr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [psr_pkg::CoordW-1:0]   point_x;
  logic signed [psr_pkg::CoordW-1:0]   point_y;
  logic                                path_start;
  logic                                path_end;
  modport source (output valid, point_x, point_y, path_start, path_end, input ready);
  modport sink   (input valid, point_x, point_y, path_start, path_end, output ready);
endinterface

interface psr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psr_pkg::CoordW-1:0]   stitch_x;
  logic signed [psr_pkg::CoordW-1:0]   stitch_y;
  logic                                item_done;
  logic                                path_done;
  logic                                step_capped;
  logic                                bad_jump;
  modport source (output valid, stitch_x, stitch_y, item_done, path_done, step_capped,
                  bad_jump, input ready);
  modport sink   (input valid, stitch_x, stitch_y, item_done, path_done, step_capped,
                  bad_jump, output ready);
endinterface

/* hdl/psr_serial_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on psr_pkg.
module psr_serial_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [psr_pkg::DiffW-1:0] a,
  input  logic [psr_pkg::DiffW-1:0] b,
  output logic                      busy,
  output logic [psr_pkg::SqW-1:0]   prod
);
  import psr_pkg::*;
  logic [SqW-1:0]   acc_r, mcand_r;
  logic [DiffW-1:0] mplier_r;
  logic [5:0]       cnt_r;
  logic             busy_r;

  // One partial product a cycle, LSB first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r   <= 1'b1;
      cnt_r    <= 6'(DiffW);
      acc_r    <= '0;
      mcand_r  <= SqW'(a);
      mplier_r <= b;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      cnt_r    <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r | start;
  assign prod = acc_r;
endmodule

/* hdl/psr_serial_div.sv */
// Restoring divider, one quotient bit per cycle; also used as a square root unit.
// Depends on psr_pkg.
module psr_serial_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      root,
  input  logic [psr_pkg::ProdW-1:0] num,
  input  logic [psr_pkg::LenW-1:0]  den,
  output logic                      busy,
  output logic [psr_pkg::ProdW-1:0] quo
);
  import psr_pkg::*;
  logic [ProdW-1:0] n_r, q_r;
  logic [ProdW+1:0] rem_r;
  logic [LenW-1:0]  d_r;
  logic [6:0]       cnt_r;
  logic             root_r, busy_r;
  logic [ProdW+1:0] rem_sh, trial;

  // Shift in one (or two for the root) dividend bits and try a subtract.
  always_comb begin
    if (root_r) begin
      rem_sh = {rem_r[ProdW-1:0], n_r[ProdW-1:ProdW-2]};
      trial  = {q_r[ProdW-1:0], 2'b01};
    end else begin
      rem_sh = {rem_r[ProdW:0], n_r[ProdW-1]};
      trial  = (ProdW+2)'(d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      root_r <= root;
      cnt_r  <= root ? 7'(ProdW/2) : 7'(ProdW);
      n_r    <= num;
      d_r    <= den;
      q_r    <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      n_r <= root_r ? (n_r << 2) : (n_r << 1);
      if (rem_sh >= trial) begin
        rem_r <= rem_sh - trial;
        q_r   <= {q_r[ProdW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[ProdW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r | start;
  assign quo  = q_r;
endmodule

/* hdl/polyline_stitch_resampler_core.sv */
// Polyline stitch resampler. Vertices are taken one request at a time and the block
// stays busy until every stitch of the current vertex has been loaded into the result
// register; a request is only taken while the result register is empty or being
// emptied. A start vertex, a single-vertex path and a bad-jump vertex finish in the
// accept cycle. A segment vertex runs on one shared bit-serial multiplier and one
// bit-serial divider that also serves as the square root unit: the two squares, the
// root and the two jump products come first, then the stitch count, and each
// intermediate stitch needs two quotients before it is sent. A receiver that holds a
// result stalls the block. Configuration may only be written while the block is idle.
// Depends on psr_pkg, psr_if, psr_serial_mul and psr_serial_div.
module polyline_stitch_resampler_core (
  input  logic                           clk,
  input  logic                           rst_n,
  psr_in_if.sink                         in_ch,
  psr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [psr_pkg::CfgW-1:0]       cfg_data
);
  import psr_pkg::*;

  psr_state_t st_r, st_nxt;
  logic [JumpW-1:0]  jump_r;
  logic [EpsW-1:0]   eps_r;
  logic [CoordW-1:0] prev_x_r, prev_y_r, base_x_r, base_y_r, cur_x_r, cur_y_r;
  logic              have_prev_r, pe_r, nx_r, ny_r, capped_r, issued_r;
  logic [DiffW-1:0]  ax_r, ay_r, qx_r;
  logic [SqW-1:0]    sum_r, jax_r, jay_r;
  logic [LenW-1:0]   len_r;
  logic [StepW:0]    k_r, count_r;
  logic [ThrW-1:0]   thr_r;
  logic [ProdW-1:0]  px_r, py_r;
  psr_res_t          res_r, res_nxt;
  logic              ovalid_r, res_load;

  logic              in_acc, out_free, unit_done, bad_w, start_w;
  logic              mul_start, mul_busy, div_start, div_busy, div_root;
  logic [DiffW-1:0]  mul_a, mul_b;
  logic [SqW-1:0]    mul_p;
  logic [ProdW-1:0]  div_num, div_q;
  logic [LenW-1:0]   div_den;
  logic              cnt_more, step_more;

  logic signed [DiffW:0]   dxw, dyw;
  logic [DiffW-1:0]        axw, ayw;
  logic signed [DiffW+1:0] offx_w, offy_w, stx_w, sty_w;

  assign out_free    = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign bad_w       = jump_r < JumpW'(eps_r);
  assign start_w     = in_ch.path_start || !have_prev_r;
  assign unit_done   = issued_r && !mul_busy && !div_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_r <= JumpW'(12288);
      eps_r  <= EpsW'(1);
    end else if (cfg_we) begin
      if (cfg_index == CfgJump) jump_r <= cfg_data[JumpW-1:0];
      else eps_r <= cfg_data[EpsW-1:0];
    end
  end

  // Shared serial units.
  psr_serial_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                        .busy(mul_busy), .prod(mul_p));
  psr_serial_div u_div (.clk, .rst_n, .start(div_start), .root(div_root), .num(div_num),
                        .den(div_den), .busy(div_busy), .quo(div_q));

  // Segment deltas against the stored vertex.
  always_comb begin
    dxw = (DiffW+1)'($signed(in_ch.point_x)) - (DiffW+1)'($signed(prev_x_r));
    dyw = (DiffW+1)'($signed(in_ch.point_y)) - (DiffW+1)'($signed(prev_y_r));
    axw = dxw[DiffW] ? DiffW'(-dxw) : dxw[DiffW-1:0];
    ayw = dyw[DiffW] ? DiffW'(-dyw) : dyw[DiffW-1:0];
  end

  // Stitch coordinates: base vertex plus the signed, rounded offset.
  always_comb begin
    offx_w = $signed({2'b00, qx_r});
    offy_w = $signed({2'b00, div_q[DiffW-1:0]});
    stx_w  = (DiffW+2)'($signed(base_x_r)) + (nx_r ? -offx_w : offx_w);
    sty_w  = (DiffW+2)'($signed(base_y_r)) + (ny_r ? -offy_w : offy_w);
  end

  // Threshold compare: stitch k exists while len > eps + k*jump, up to the cap.
  assign cnt_more  = (ThrW'(len_r) > thr_r);
  assign step_more = cnt_more && (k_r <= (StepW+1)'(MaxSteps));

  // Sequencer transitions.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_acc && !bad_w && !start_w) st_nxt = ST_SQX;
      ST_SQX:   if (unit_done) st_nxt = ST_SQY;
      ST_SQY:   if (unit_done) st_nxt = ST_ROOT;
      ST_ROOT:  if (unit_done) st_nxt = ST_JX;
      ST_JX:    if (unit_done) st_nxt = ST_JY;
      ST_JY:    if (unit_done) st_nxt = ST_CNT;
      ST_CNT:   if (!step_more) st_nxt = ST_FIRST;
      ST_FIRST: if (out_free) begin
        if (count_r != '0) st_nxt = ST_DIVX;
        else st_nxt = pe_r ? ST_LAST : ST_IDLE;
      end
      ST_DIVX:  if (unit_done) st_nxt = ST_DIVY;
      ST_DIVY:  if (unit_done) st_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) begin
        if (k_r != count_r) st_nxt = ST_DIVX;
        else st_nxt = pe_r ? ST_LAST : ST_IDLE;
      end
      ST_LAST:  if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Unit launches and result loads.
  always_comb begin
    mul_start = 1'b0; div_start = 1'b0; div_root = 1'b0;
    mul_a = ax_r; mul_b = ax_r; div_num = px_r; div_den = len_r;
    res_load = 1'b0; res_nxt = res_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) begin
        if (bad_w) begin
          res_load = 1'b1;
          res_nxt = '{x:'0, y:'0, item_done:1'b1, path_done:in_ch.path_end,
                      capped:1'b0, bad:1'b1};
        end else if (start_w && in_ch.path_end) begin
          res_load = 1'b1;
          res_nxt = '{x:in_ch.point_x, y:in_ch.point_y, item_done:1'b1,
                      path_done:1'b1, capped:1'b0, bad:1'b0};
        end
      end
      ST_SQX:  mul_start = !issued_r;
      ST_SQY: begin
        mul_start = !issued_r;
        mul_a = ay_r; mul_b = ay_r;
      end
      ST_ROOT: begin
        div_start = !issued_r; div_root = 1'b1;
        div_num = ProdW'(sum_r);
      end
      ST_JX: begin
        mul_start = !issued_r;
        mul_b = DiffW'(jump_r);
      end
      ST_JY: begin
        mul_start = !issued_r;
        mul_a = ay_r; mul_b = DiffW'(jump_r);
      end
      ST_CNT: ;
      ST_FIRST: if (out_free) begin
        res_load = 1'b1;
        res_nxt = '{x:base_x_r, y:base_y_r, item_done:(count_r == '0) && !pe_r,
                    path_done:1'b0, capped:capped_r, bad:1'b0};
      end
      ST_DIVX: div_start = !issued_r;
      ST_DIVY: begin
        div_start = !issued_r;
        div_num = py_r;
      end
      ST_EMIT: if (out_free) begin
        res_load = 1'b1;
        res_nxt = '{x:sat_coord(stx_w), y:sat_coord(sty_w),
                    item_done:(k_r == count_r) && !pe_r, path_done:1'b0,
                    capped:capped_r, bad:1'b0};
      end
      ST_LAST: if (out_free) begin
        res_load = 1'b1;
        res_nxt = '{x:cur_x_r, y:cur_y_r, item_done:1'b1, path_done:1'b1,
                    capped:capped_r, bad:1'b0};
      end
      default: ;
    endcase
  end

  // Control, state and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; have_prev_r <= 1'b0; ovalid_r <= 1'b0; issued_r <= 1'b0;
      prev_x_r <= '0; prev_y_r <= '0; count_r <= '0;
    end else begin
      st_r     <= st_nxt;
      ovalid_r <= res_load || (ovalid_r && !out_ch.ready);
      issued_r <= (issued_r && !unit_done) || mul_start || div_start;
      if (res_load) res_r <= res_nxt;
      unique case (st_r)
        ST_IDLE: if (in_acc) begin
          prev_x_r <= in_ch.point_x; prev_y_r <= in_ch.point_y;
          have_prev_r <= !in_ch.path_end;
          base_x_r <= prev_x_r; base_y_r <= prev_y_r;
          cur_x_r <= in_ch.point_x; cur_y_r <= in_ch.point_y; pe_r <= in_ch.path_end;
          ax_r <= axw; ay_r <= ayw; nx_r <= dxw[DiffW]; ny_r <= dyw[DiffW];
          k_r <= (StepW+1)'(1); count_r <= '0;
          thr_r <= ThrW'(eps_r) + ThrW'(jump_r);
        end
        ST_SQX:  if (unit_done) sum_r <= mul_p;
        ST_SQY:  if (unit_done) sum_r <= sum_r + mul_p;
        ST_ROOT: if (unit_done) len_r <= div_q[LenW-1:0];
        ST_JX:   if (unit_done) jax_r <= mul_p;
        ST_JY:   if (unit_done) jay_r <= mul_p;
        ST_CNT: begin
          if (step_more) begin
            count_r <= k_r; k_r <= k_r + (StepW+1)'(1);
            thr_r <= thr_r + ThrW'(jump_r);
          end else begin
            // Past the cap a stitch that would still exist marks the segment.
            capped_r <= cnt_more;
            k_r <= (StepW+1)'(1);
            px_r <= ProdW'(jax_r) + ProdW'(len_r >> 1);
            py_r <= ProdW'(jay_r) + ProdW'(len_r >> 1);
          end
        end
        ST_FIRST: ;
        ST_DIVX: if (unit_done) qx_r <= div_q[DiffW-1:0];
        ST_DIVY: ;
        ST_EMIT: if (out_free) begin
          k_r <= k_r + (StepW+1)'(1);
          px_r <= px_r + ProdW'(jax_r);
          py_r <= py_r + ProdW'(jay_r);
        end
        ST_LAST: ;
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.stitch_x    = res_r.x;
  assign out_ch.stitch_y    = res_r.y;
  assign out_ch.item_done   = res_r.item_done;
  assign out_ch.path_done   = res_r.path_done;
  assign out_ch.step_capped = res_r.capped;
  assign out_ch.bad_jump    = res_r.bad;

  // A held result stays valid and unchanged until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(res_r)) else $error("held result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ch.ready) else $error("input taken while busy");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (StepW+1)'(MaxSteps)) else $error("stitch count beyond cap");
endmodule

/* verif/polyline_stitch_resampler_core_tb.sv */
// Testbench for polyline_stitch_resampler_core: directed and random polylines,
// with the stitch stream checked against an in-bench predictor.
// Depends on psr_pkg, psr_in_if and psr_out_if from the RTL.
module polyline_stitch_resampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psr_pkg::*;

  localparam longint CoordHi = (64'sd1 <<< (CoordW - 1)) - 1;
  localparam longint CoordLo = -CoordHi - 1;
  localparam longint CycleLimit = 40_000_000;

  // Predicts the stitch stream and compares what the block sends.
  class stitch_board;
    psr_res_t pending[$];
    longint unsigned jump_reg;
    longint unsigned eps_reg;
    longint last_x;
    longint last_y;
    bit have_last;
    int errors;

    function new();
      jump_reg = 12288;
      eps_reg = 1;
      last_x = 0;
      last_y = 0;
      have_last = 0;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    static function logic [CoordW-1:0] clamp_coord(longint v);
      if (v > CoordHi) return CoordHi[CoordW-1:0];
      if (v < CoordLo) return CoordLo[CoordW-1:0];
      return v[CoordW-1:0];
    endfunction

    static function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function longint offset_along(longint unsigned k, longint unsigned a, bit neg,
                                  longint unsigned len);
      longint unsigned m;
      if (len == 0) return 0;
      m = (k * jump_reg * a + (len >> 1)) / len;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function void push_stitch(longint x, longint y, bit pdone, bit capped, bit bad);
      psr_res_t r;
      r.x = clamp_coord(x);
      r.y = clamp_coord(y);
      r.item_done = 0;
      r.path_done = pdone;
      r.capped = capped;
      r.bad = bad;
      pending.insert(pending.size(), r);
    endfunction

    // Works out every stitch one accepted vertex causes.
    function void note_vertex(logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
                              bit ps, bit pe);
      longint x;
      longint y;
      longint dx;
      longint dy;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned len;
      longint unsigned count;
      bit capped;
      int before_n;
      x = px;
      y = py;
      before_n = pending.size();
      if (jump_reg < eps_reg) begin
        push_stitch(0, 0, pe, 0, 1);
      end else if (ps || !have_last) begin
        if (pe) push_stitch(x, y, 1, 0, 0);
      end else begin
        dx = x - last_x;
        dy = y - last_y;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= 64'd1 << 31 || ay >= 64'd1 << 31)
          len = int_root((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
        else
          len = int_root(ax * ax + ay * ay);
        count = 0;
        for (longint unsigned k = 1; k <= MaxSteps && len > eps_reg + k * jump_reg; k++)
          count++;
        capped = (count == MaxSteps) && (len > eps_reg + (MaxSteps + 1) * jump_reg);
        push_stitch(last_x, last_y, 0, capped, 0);
        for (longint unsigned k = 1; k <= count; k++)
          push_stitch(last_x + offset_along(k, ax, dx < 0, len),
                      last_y + offset_along(k, ay, dy < 0, len), 0, capped, 0);
        if (pe) push_stitch(x, y, 1, capped, 0);
      end
      if (pending.size() > before_n) pending[$].item_done = 1;
      last_x = x;
      last_y = y;
      have_last = !pe;
    endfunction

    task check_stitch(psr_res_t got);
      psr_res_t want;
      if (pending.size() == 0) begin
        report("stitch with none pending, x", $signed(got.x), 0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report("stitch_x", $signed(got.x), $signed(want.x));
      if (got.y !== want.y) report("stitch_y", $signed(got.y), $signed(want.y));
      if (got.item_done !== want.item_done) report("item_done", got.item_done, want.item_done);
      if (got.path_done !== want.path_done) report("path_done", got.path_done, want.path_done);
      if (got.capped !== want.capped) report("step_capped", got.capped, want.capped);
      if (got.bad !== want.bad) report("bad_jump", got.bad, want.bad);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  psr_in_if in_ch();
  psr_out_if out_ch();

  stitch_board board;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  longint cycles;
  longint cur_x;
  longint cur_y;

  polyline_stitch_resampler_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Cycle count and the run's time limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("polyline_stitch_resampler_core_tb: done, errors");
      $finish;
    end
  end

  // Check each stitch the block hands over.
  always @(posedge clk) begin
    psr_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.stitch_x;
      got.y = out_ch.stitch_y;
      got.item_done = out_ch.item_done;
      got.path_done = out_ch.path_done;
      got.capped = out_ch.step_capped;
      got.bad = out_ch.bad_jump;
      board.check_stitch(got);
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 3000;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Present one vertex and wait until the block takes the request.
  task send_vertex(longint x, longint y, bit ps, bit pe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.point_x = x[CoordW-1:0];
    in_ch.point_y = y[CoordW-1:0];
    in_ch.path_start = ps;
    in_ch.path_end = pe;
    do @(posedge clk); while (!in_ch.ready);
    board.note_vertex(x[CoordW-1:0], y[CoordW-1:0], ps, pe);
    cur_x = x;
    cur_y = y;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Let every pending stitch arrive, then allow for a start vertex still in flight.
  task drain();
    in_ch.valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_reg(logic [0:0] idx, longint unsigned value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CfgW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CfgJump) board.jump_reg = value & 64'h7FFFFF;
    else board.eps_reg = value & 64'hFFF;
  endtask

  task set_regs(longint unsigned jump, longint unsigned eps);
    drain();
    write_reg(CfgJump, jump);
    write_reg(CfgEps, eps);
  endtask

  // Next vertex near the current one, or anywhere now and then.
  task next_point(output longint x, output longint y);
    longint span;
    if ($urandom_range(99) < 6) begin
      x = longint'($signed(24'($urandom)));
      y = longint'($signed(24'($urandom)));
    end else begin
      span = longint'(board.jump_reg) * $urandom_range(0, 8) + $urandom_range(0, 4096);
      if (span > 64'd1 << 22) span = 64'd1 << 22;
      x = cur_x + $urandom_range(0, 2 * span) - span;
      y = cur_y + $urandom_range(0, 2 * span) - span;
      x = x > CoordHi ? CoordHi : (x < CoordLo ? CoordLo : x);
      y = y > CoordHi ? CoordHi : (y < CoordLo ? CoordLo : y);
    end
  endtask

  // A run of random polylines; some vertices carry random flags.
  task random_paths(int n_items);
    int sent;
    int plen;
    longint x;
    longint y;
    sent = 0;
    while (sent < n_items) begin
      plen = $urandom_range(1, 6);
      for (int i = 0; i < plen && sent < n_items; i++) begin
        next_point(x, y);
        if ($urandom_range(99) < 10)
          send_vertex(x, y, $urandom_range(1), $urandom_range(1));
        else
          send_vertex(x, y, i == 0, i == plen - 1);
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    hold_req = 0;
    cur_x = 0;
    cur_y = 0;
    send_idle_pct = 11;
    recv_idle_pct = 56;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgJump;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.path_start = 1'b0;
    in_ch.path_end = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: single vertex paths at the extremes, a capped diagonal,
    // a zero-length segment, a vertex with no stored one, an unfinished path.
    send_vertex(CoordHi, CoordLo, 1, 1);
    send_vertex(CoordLo, CoordHi, 1, 1);
    send_vertex(CoordLo, CoordLo, 1, 0);
    send_vertex(CoordHi, CoordHi, 0, 1);
    send_vertex(100, -200, 0, 0);
    send_vertex(100, -200, 0, 0);
    send_vertex(30000, -5000, 0, 1);
    send_vertex(7, 7, 1, 0);
    send_vertex(-40000, 9000, 1, 0);
    send_vertex(-20000, 1000, 0, 1);
    // Zero jump without error: every segment hits the cap.
    set_regs(0, 0);
    send_vertex(0, 0, 1, 0);
    send_vertex(5000, 5000, 0, 1);
    // Jump below epsilon: one flagged result per vertex.
    set_regs(0, 4095);
    send_vertex(1, 2, 1, 0);
    send_vertex(3, 4, 0, 0);
    send_vertex(CoordHi, CoordLo, 0, 1);
    set_regs(8388607, 4095);
    send_vertex(CoordLo, CoordLo, 1, 0);
    send_vertex(CoordHi, CoordHi, 0, 1);
    set_regs(4095, 4095);
    send_vertex(0, 0, 1, 0);
    send_vertex(20000, 0, 0, 1);

    // Random part: receiver idles first, then the sender does, then neither.
    set_regs(12288, 1);
    random_paths(56);
    set_regs(4096, 0);
    random_paths(56);
    send_idle_pct = 56;
    recv_idle_pct = 11;
    set_regs($urandom_range(1000, 20000), $urandom_range(0, 4095));
    hold_req = 1;
    random_paths(56);
    set_regs(100, 300);
    random_paths(56);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(2000, 2000);
    random_paths(56);
    set_regs($urandom_range(3000, 9000), $urandom_range(0, 64));
    random_paths(56);

    drain();
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("polyline_stitch_resampler_core_tb: done, clean");
    else
      $display("polyline_stitch_resampler_core_tb: done, errors");
    $finish;
  end
endmodule
